FILE: src/rmj_pkg.sv
package rmj_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAG_W      = 32;
  localparam int OUT_W      = 32;
  localparam int CFG_W      = 32;
  localparam int SUM_W      = 2 * MAG_W;
  localparam int ROOT_W     = MAG_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SQ_REM_W   = ROOT_W + 2;
  localparam int PP_W       = MAG_W + SUM_W;
  localparam int DIV_D_W    = SUM_W;
  // widest quotient: |p| * |v x p| / s <= |v| * 2^F < 2^(MAG_W + F)
  localparam int DIV_Q_W    = MAG_W + FRAC_BITS;
  localparam int DIV_N_W    = DIV_D_W + DIV_Q_W;
  localparam int R_DLY      = DIV_Q_W - SQRT_STEPS;

  localparam logic [CFG_W-1:0] MIN_RANGE_SQ_RESET = CFG_W'(66);

  localparam logic [DIV_Q_W-1:0] NEG_MAG_MAX = DIV_Q_W'(1) << (OUT_W - 1);
  localparam logic [DIV_Q_W-1:0] POS_MAG_MAX = NEG_MAG_MAX - DIV_Q_W'(1);
  localparam logic [OUT_W-1:0]   SAT_NEG     = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]   SAT_POS     = {1'b0, {(OUT_W-1){1'b1}}};

  typedef struct packed {
    logic               deg;
    logic               nx;
    logic               ny;
    logic               ndiff;
    logic [MAG_W-1:0]   mx;
    logic [MAG_W-1:0]   my;
    logic [SUM_W-1:0]   s;
  } side_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             sat;
  } clip_t;

  function automatic clip_t clip_mag(input logic neg, input logic [DIV_Q_W-1:0] mag);
    clip_t c;
    logic [DIV_Q_W-1:0] neg_mag;
    neg_mag = ~mag + DIV_Q_W'(1);
    c.sat = 1'b0;
    if (neg) begin
      if (mag > NEG_MAG_MAX) begin
        c.value = SAT_NEG;
        c.sat   = 1'b1;
      end else begin
        c.value = neg_mag[OUT_W-1:0];
      end
    end else begin
      if (mag > POS_MAG_MAX) begin
        c.value = SAT_POS;
        c.sat   = 1'b1;
      end else begin
        c.value = mag[OUT_W-1:0];
      end
    end
    return c;
  endfunction

endpackage

FILE: src/rmj_div_pipe.sv
// Restoring divider, one quotient bit per stage, each stage registered.
// Requires num >> DIV_Q_W < den (quotient fits DIV_Q_W bits).
module rmj_div_pipe import rmj_pkg::*; (
  input  logic               clk,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic [DIV_Q_W-1:0] quo
);

  logic [DIV_D_W-1:0] rem_q [DIV_Q_W];
  logic [DIV_Q_W-1:0] quo_q [DIV_Q_W];
  logic [DIV_D_W-1:0] den_q [DIV_Q_W];
  logic [DIV_Q_W-1:0] low_q [DIV_Q_W-1];

  for (genvar i = 0; i < DIV_Q_W; i++) begin : g_stage
    logic [DIV_D_W-1:0] rem_in;
    logic [DIV_Q_W-1:0] quo_in;
    logic [DIV_D_W-1:0] den_in;
    logic [DIV_Q_W-1:0] low_in;
    logic [DIV_D_W:0]   t;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    if (i == 0) begin : g_first
      assign rem_in = num[DIV_N_W-1:DIV_Q_W];
      assign quo_in = '0;
      assign den_in = den;
      assign low_in = num[DIV_Q_W-1:0];
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign den_in = den_q[i-1];
      assign low_in = low_q[i-1];
    end

    assign t    = {rem_in, low_in[DIV_Q_W-1]};
    assign ge   = t >= {1'b0, den_in};
    assign diff = t - {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_q[i] <= ge ? diff[DIV_D_W-1:0] : t[DIV_D_W-1:0];
      quo_q[i] <= {quo_in[DIV_Q_W-2:0], ge};
      den_q[i] <= den_in;
    end

    if (i < DIV_Q_W - 1) begin : g_low
      always_ff @(posedge clk) begin
        low_q[i] <= {low_in[DIV_Q_W-2:0], 1'b0};
      end
    end
  end

  assign quo = quo_q[DIV_Q_W-1];

endmodule

FILE: src/radar_measurement_jacobian.sv
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+-----------------------------------------
// input     | start (accepted when !busy)    | pos_x, pos_y, vel_x, vel_y
// result    | done, one-cycle strobe         | range_dx/dy, bearing_dx/dy, rate_dx/dy,
//           |                                | degenerate, saturated
// config    | cfg_valid / cfg_ready          | cfg_data -> min_range_sq
//
// Fully pipelined: one state per cycle, busy is never raised.
// Results are Q16.16. The depth is set by the two chained bit-per-stage dividers
// for the range-rate terms; the 32-step root runs beside the first of them. rst
// is synchronous and clears the valid pipe and the threshold (to 66). The
// receiver cannot stall; results come out in input order.
module radar_measurement_jacobian import rmj_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic signed [MAG_W-1:0] pos_x,
  input  logic signed [MAG_W-1:0] pos_y,
  input  logic signed [MAG_W-1:0] vel_x,
  input  logic signed [MAG_W-1:0] vel_y,
  output logic                    done,
  output logic signed [OUT_W-1:0] range_dx,
  output logic signed [OUT_W-1:0] range_dy,
  output logic signed [OUT_W-1:0] bearing_dx,
  output logic signed [OUT_W-1:0] bearing_dy,
  output logic signed [OUT_W-1:0] rate_dx,
  output logic signed [OUT_W-1:0] rate_dy,
  output logic                    degenerate,
  output logic                    saturated
);

  localparam int LATENCY = 2 * DIV_Q_W + 6;

  logic [CFG_W-1:0] min_range_sq;
  logic             accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range_sq <= MIN_RANGE_SQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_range_sq <= cfg_data;
    end
  end

  // stage 0: magnitudes
  logic [MAG_W-1:0] ux, uy, mag_x, mag_y;
  logic                    v0, nx0, ny0;
  logic [MAG_W-1:0]        mx0, my0;
  logic signed [MAG_W-1:0] px0, py0, vx0, vy0;

  always_comb begin
    ux    = pos_x;
    uy    = pos_y;
    mag_x = ux[MAG_W-1] ? (~ux + MAG_W'(1)) : ux;
    mag_y = uy[MAG_W-1] ? (~uy + MAG_W'(1)) : uy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
    nx0 <= pos_x[MAG_W-1];
    ny0 <= pos_y[MAG_W-1];
    mx0 <= mag_x;
    my0 <= mag_y;
    px0 <= pos_x;
    py0 <= pos_y;
    vx0 <= vel_x;
    vy0 <= vel_y;
  end

  // stage 1: squares and cross products
  logic                    v1, nx1, ny1;
  logic [MAG_W-1:0]        mx1, my1;
  logic [SUM_W-1:0]        sxx1, syy1;
  logic signed [SUM_W-1:0] a1, b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    nx1  <= nx0;
    ny1  <= ny0;
    mx1  <= mx0;
    my1  <= my0;
    sxx1 <= mx0 * mx0;
    syy1 <= my0 * my0;
    a1   <= vx0 * py0;
    b1   <= vy0 * px0;
  end

  // stage 2: squared range, |vx py - vy px|
  logic signed [SUM_W:0] diff1;
  logic [SUM_W-1:0]      mdiff1;
  logic                  v2;
  side_t                 side2;
  logic [SUM_W-1:0]      mdiff2;

  always_comb begin
    diff1  = a1 - b1;
    mdiff1 = diff1[SUM_W] ? SUM_W'(-diff1) : diff1[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    side2.deg   <= 1'b0;
    side2.nx    <= nx1;
    side2.ny    <= ny1;
    side2.ndiff <= diff1[SUM_W];
    side2.mx    <= mx1;
    side2.my    <= my1;
    side2.s     <= sxx1 + syy1;
    mdiff2      <= mdiff1;
  end

  // stage 3: threshold check, 32x64 partial products
  logic             v3;
  side_t            side3;
  logic [SUM_W-1:0] ppxl3, ppxh3, ppyl3, ppyh3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    side3.nx    <= side2.nx;
    side3.ny    <= side2.ny;
    side3.ndiff <= side2.ndiff;
    side3.mx    <= side2.mx;
    side3.my    <= side2.my;
    side3.s     <= side2.s;
    side3.deg   <= (side2.s == '0) ||
                   (side2.s < SUM_W'({min_range_sq, {FRAC_BITS{1'b0}}}));
    ppxl3       <= side2.mx * mdiff2[MAG_W-1:0];
    ppxh3       <= side2.mx * mdiff2[SUM_W-1:MAG_W];
    ppyl3       <= side2.my * mdiff2[MAG_W-1:0];
    ppyh3       <= side2.my * mdiff2[SUM_W-1:MAG_W];
  end

  // stage 4: rate numerators scaled by 2^F
  logic               v4;
  side_t              side4;
  logic [DIV_N_W-1:0] numx4, numy4;
  logic [PP_W-1:0]    prodx3, prody3;

  assign prodx3 = {ppxh3, {MAG_W{1'b0}}} + PP_W'(ppxl3);
  assign prody3 = {ppyh3, {MAG_W{1'b0}}} + PP_W'(ppyl3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    side4 <= side3;
    numx4 <= {prodx3, {FRAC_BITS{1'b0}}};
    numy4 <= {prody3, {FRAC_BITS{1'b0}}};
  end

  // first rate division by s
  logic [DIV_Q_W-1:0] q1x, q1y;

  rmj_div_pipe u_rate1_x (.clk(clk), .num(numx4), .den(side4.s), .quo(q1x));
  rmj_div_pipe u_rate1_y (.clk(clk), .num(numy4), .den(side4.s), .quo(q1y));

  // integer square root, two radicand bits per stage
  logic [SQ_REM_W-1:0] sq_rem  [SQRT_STEPS];
  logic [ROOT_W-1:0]   sq_root [SQRT_STEPS];
  logic [SUM_W-1:0]    sq_val  [SQRT_STEPS-1];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    logic [SQ_REM_W-1:0] rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [SUM_W-1:0]    val_in;
    logic [SQ_REM_W+1:0] t;
    logic [SQ_REM_W+1:0] trial;
    logic [SQ_REM_W+1:0] sub;
    logic                ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = side4.s;
    end else begin : g_next
      assign rem_in  = sq_rem[i-1];
      assign root_in = sq_root[i-1];
      assign val_in  = sq_val[i-1];
    end

    assign t     = {rem_in, val_in[SUM_W-1:SUM_W-2]};
    assign trial = (SQ_REM_W+2)'({root_in, 2'b01});
    assign ge    = t >= trial;
    assign sub   = t - trial;

    always_ff @(posedge clk) begin
      sq_rem[i]  <= ge ? sub[SQ_REM_W-1:0] : t[SQ_REM_W-1:0];
      sq_root[i] <= {root_in[ROOT_W-2:0], ge};
    end

    if (i < SQRT_STEPS - 1) begin : g_val
      always_ff @(posedge clk) begin
        sq_val[i] <= {val_in[SUM_W-3:0], 2'b00};
      end
    end
  end

  // align root with the first rate quotient
  logic [ROOT_W-1:0] r_dly [R_DLY];

  always_ff @(posedge clk) begin
    r_dly[0] <= sq_root[SQRT_STEPS-1];
    for (int k = 1; k < R_DLY; k++) begin
      r_dly[k] <= r_dly[k-1];
    end
  end

  // side data and valid travel beside both divider passes
  side_t side_d [2*DIV_Q_W];
  logic  [2*DIV_Q_W-1:0] v_d;

  always_ff @(posedge clk) begin
    side_d[0] <= side4;
    for (int k = 1; k < 2 * DIV_Q_W; k++) begin
      side_d[k] <= side_d[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d <= '0;
    end else begin
      v_d <= {v_d[2*DIV_Q_W-2:0], v4};
    end
  end

  side_t             side_e;
  logic [ROOT_W-1:0] r_e;

  assign side_e = side_d[DIV_Q_W-1];
  assign r_e    = r_dly[R_DLY-1];

  // second pass: range, bearing and second rate divisions
  logic [DIV_Q_W-1:0] q_rng_x, q_rng_y, q_brg_x, q_brg_y, q2x, q2y;

  rmj_div_pipe u_range_x (
    .clk(clk), .num(DIV_N_W'({side_e.mx, {FRAC_BITS{1'b0}}})),
    .den(DIV_D_W'(r_e)), .quo(q_rng_x));
  rmj_div_pipe u_range_y (
    .clk(clk), .num(DIV_N_W'({side_e.my, {FRAC_BITS{1'b0}}})),
    .den(DIV_D_W'(r_e)), .quo(q_rng_y));
  rmj_div_pipe u_bearing_x (
    .clk(clk), .num(DIV_N_W'({side_e.my, {(2*FRAC_BITS){1'b0}}})),
    .den(side_e.s), .quo(q_brg_x));
  rmj_div_pipe u_bearing_y (
    .clk(clk), .num(DIV_N_W'({side_e.mx, {(2*FRAC_BITS){1'b0}}})),
    .den(side_e.s), .quo(q_brg_y));
  rmj_div_pipe u_rate2_x (
    .clk(clk), .num(DIV_N_W'(q1y)), .den(DIV_D_W'(r_e)), .quo(q2x));
  rmj_div_pipe u_rate2_y (
    .clk(clk), .num(DIV_N_W'(q1x)), .den(DIV_D_W'(r_e)), .quo(q2y));

  // output stage: sign, clip, degenerate override
  side_t side_f;
  clip_t c_rx, c_ry, c_bx, c_by, c_tx, c_ty;

  assign side_f = side_d[2*DIV_Q_W-1];

  always_comb begin
    c_rx = clip_mag(side_f.nx, q_rng_x);
    c_ry = clip_mag(side_f.ny, q_rng_y);
    c_bx = clip_mag(~side_f.ny, q_brg_x);
    c_by = clip_mag(side_f.nx, q_brg_y);
    c_tx = clip_mag(side_f.ny ^ side_f.ndiff, q2x);
    c_ty = clip_mag(~(side_f.nx ^ side_f.ndiff), q2y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_d[2*DIV_Q_W-1];
    end
    if (side_f.deg) begin
      range_dx   <= '0;
      range_dy   <= '0;
      bearing_dx <= '0;
      bearing_dy <= '0;
      rate_dx    <= '0;
      rate_dy    <= '0;
      degenerate <= 1'b1;
      saturated  <= 1'b0;
    end else begin
      range_dx   <= c_rx.value;
      range_dy   <= c_ry.value;
      bearing_dx <= c_bx.value;
      bearing_dy <= c_by.value;
      rate_dx    <= c_tx.value;
      rate_dy    <= c_ty.value;
      degenerate <= 1'b0;
      saturated  <= c_rx.sat | c_ry.sat | c_bx.sat | c_by.sat | c_tx.sat | c_ty.sat;
    end
  end

  // every accepted transaction comes out after a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result strobe missing after pipeline latency");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> range_dx == '0 && range_dy == '0 && bearing_dx == '0 &&
                           bearing_dy == '0 && rate_dx == '0 && rate_dy == '0 &&
                           !saturated)
    else $error("degenerate result with non-zero entries");

  // |px|, |py| <= r, so the range terms stay within one unit
  a_range_unit: assert property (@(posedge clk) disable iff (rst)
    done && !degenerate |->
      range_dx <= $signed(OUT_W'(1) << FRAC_BITS) &&
      range_dx >= -$signed(OUT_W'(1) << FRAC_BITS) &&
      range_dy <= $signed(OUT_W'(1) << FRAC_BITS) &&
      range_dy >= -$signed(OUT_W'(1) << FRAC_BITS))
    else $error("range term exceeds unit magnitude");

endmodule

FILE: dv/radar_measurement_jacobian_test.sv
`timescale 1ns / 100ps

module radar_measurement_jacobian_test;
  import rmj_pkg::*;

  typedef struct packed {
    logic [31:0] px, py, vx, vy;
  } state_t;

  typedef struct packed {
    logic [31:0] rdx, rdy, bdx, bdy, vdx, vdy;
    logic        deg, sat;
  } jacobian_t;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done, degenerate, saturated;
  logic [CFG_W-1:0] cfg_data;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
  logic signed [31:0] range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy;

  state_t    pending_states[$];
  jacobian_t expected_jac[$];
  logic [31:0] threshold;
  int idle_pct;
  int errors;

  radar_measurement_jacobian dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
    .done(done), .range_dx(range_dx), .range_dy(range_dy),
    .bearing_dx(bearing_dx), .bearing_dy(bearing_dy),
    .rate_dx(rate_dx), .rate_dy(rate_dy),
    .degenerate(degenerate), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 2000000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] saturate(input logic neg, input logic [127:0] m,
                                           inout logic sat);
    logic [31:0] v;
    if (neg) begin
      if (m > 128'h8000_0000) begin
        sat = 1'b1;
        v = 32'h8000_0000;
      end else begin
        v = 32'(-m);
      end
    end else if (m > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      v = 32'h7FFF_FFFF;
    end else begin
      v = m[31:0];
    end
    return v;
  endfunction

  function automatic jacobian_t jacobian_of(input state_t st, input logic [31:0] min_sq);
    jacobian_t j;
    logic nx, ny, ndiff, sat;
    logic [31:0] mx, my;
    logic [63:0] s, r;
    logic signed [65:0] a, b, d;
    logic [127:0] mdiff;
    nx = st.px[31];
    ny = st.py[31];
    mx = nx ? -st.px : st.px;
    my = ny ? -st.py : st.py;
    s = 64'(mx) * 64'(mx) + 64'(my) * 64'(my);
    j = '{default: '0};
    if (s == 0 || s < (64'(min_sq) << FRAC_BITS)) begin
      j.deg = 1'b1;
      return j;
    end
    sat = 1'b0;
    r = int_sqrt(s);
    j.rdx = saturate(nx, (128'(mx) << FRAC_BITS) / r, sat);
    j.rdy = saturate(ny, (128'(my) << FRAC_BITS) / r, sat);
    j.bdx = saturate(!ny, (128'(my) << (2 * FRAC_BITS)) / s, sat);
    j.bdy = saturate(nx, (128'(mx) << (2 * FRAC_BITS)) / s, sat);
    a = 66'(signed'(st.vx)) * 66'(signed'(st.py));
    b = 66'(signed'(st.vy)) * 66'(signed'(st.px));
    ndiff = a < b;
    d = ndiff ? b - a : a - b;
    mdiff = 128'(d);
    j.vdx = saturate(ny != ndiff, ((((128'(my) * mdiff) << FRAC_BITS) / s) / r), sat);
    j.vdy = saturate(nx == ndiff, ((((128'(mx) * mdiff) << FRAC_BITS) / s) / r), sat);
    j.sat = sat;
    return j;
  endfunction

  // driver: present the head of the pending list at the falling edge
  always @(negedge clk) begin
    if (!rst && pending_states.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      start <= 1'b1;
      pos_x <= pending_states[0].px;
      pos_y <= pending_states[0].py;
      vel_x <= pending_states[0].vx;
      vel_y <= pending_states[0].vy;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: accept transactions and check results at the rising edge
  always @(posedge clk) begin
    jacobian_t got, want;
    if (!rst) begin
      if (start && !busy) begin
        expected_jac.push_back(jacobian_of(pending_states[0], threshold));
        pending_states.pop_front();
      end
      if (done) begin
        got = '{range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy,
                degenerate, saturated};
        if (expected_jac.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_jac.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_field();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h40000) - 32'h20000;
      2: v = $urandom_range(0, 32'h4000000) - 32'h2000000;
      3: v = {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0;
          1: v = 32'h1;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic wait_idle();
    while (pending_states.size() > 0 || expected_jac.size() > 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    threshold = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_state(input logic [31:0] px, py, vx, vy);
    state_t st;
    st = '{px, py, vx, vy};
    pending_states.push_back(st);
  endtask

  initial begin
    logic [31:0] levels[6];
    int idles[6];
    errors = 0;
    threshold = MIN_RANGE_SQ_RESET;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero state, extremes, sub-threshold ranges, unit-scale states
    push_state(0, 0, 0, 0);
    push_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_state(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_state(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    push_state(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_state(32'd8, 32'd0, 32'd1, 32'd1);              // s far below 66<<16
    push_state(32'd8, 32'd2, 32'd1, 32'd1);              // s also below 66<<16
    push_state(32'd9, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
    push_state(32'hFFFF_FFF7, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    push_state(32'd0, 32'hFFFF_FFF7, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_state(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
    push_state(32'hFFFF_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    push_state(32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0001_0000);
    push_state(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
    push_state(32'h1000, 32'h0, 32'h0, 32'h1000);
    wait_idle();

    levels = '{32'h0, 32'hFFFF_FFFF, 32'd66, 32'd1, 32'h0001_0000, 32'h0};
    idles  = '{0, 52, 0, 52, 7, 0};
    for (int p = 0; p < 6; p++) begin
      write_threshold(p == 5 ? 32'($urandom) : levels[p]);
      idle_pct = idles[p];
      if (threshold == 0) push_state(0, 0, $urandom, $urandom);
      for (int i = 0; i < 315; i++) begin
        // idle_pct changes here while states are only queued; the phase runs at idles[p]
        if (i % 100 == 50) idle_pct = 0;
        if (i % 100 == 80) idle_pct = idles[p];
        push_state(rand_field(), rand_field(), rand_field(), rand_field());
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
